[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for the range-sum tree RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// clocked property, masked while reset is asserted
`define STST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked property, checked during reset as well
`define STST_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STST_ASSERT(lbl, clk, rst_n, prop, msg)
`define STST_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/stst_pkg.sv]
// ----------------------------------------------------------------------------
// stst_pkg
// Shared constants and types of the segment tree range-sum block.
// ----------------------------------------------------------------------------
package stst_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int TREE_NODES   = 2 * NUM_ELEMENTS;
  localparam int IDX_W        = 10;
  localparam int END_W        = 11;
  localparam int VALUE_W      = 32;
  localparam int SUM_W        = 43;
  localparam int NODE_W       = $clog2(TREE_NODES);
  localparam int POS_W        = NODE_W + 1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef struct packed {
    logic  we;
    node_t waddr;
    sum_t  wdata;
    node_t raddr0;
    node_t raddr1;
  } mem_req_t;

endpackage

[hw/rtl/stst_tree_mem.sv]
// ----------------------------------------------------------------------------
// stst_tree_mem
// Node-sum memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module stst_tree_mem (
  input  logic              clk,
  input  stst_pkg::mem_req_t req,
  output stst_pkg::sum_t    rdata0,
  output stst_pkg::sum_t    rdata1
);

  stst_pkg::sum_t mem [stst_pkg::TREE_NODES];
  stst_pkg::sum_t rdata0_r;
  stst_pkg::sum_t rdata1_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0_r <= mem[req.raddr0];
    rdata1_r <= mem[req.raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

[hw/rtl/stst_walk.sv]
// ----------------------------------------------------------------------------
// stst_walk
// Tree walker: clearing pass, leaf update with ancestor recompute, range query.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stst_walk (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_cmd,
  input  logic [stst_pkg::IDX_W-1:0]           in_index,
  input  logic [stst_pkg::END_W-1:0]           in_range_end,
  input  logic signed [stst_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  output logic signed [stst_pkg::SUM_W-1:0]    out_range_sum,
  output stst_pkg::mem_req_t                   mem_req,
  input  stst_pkg::sum_t                       rdata0,
  input  stst_pkg::sum_t                       rdata1
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_UPD   = 4'b0100,
    ST_QRY   = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  stst_pkg::node_t clr_r, clr_nxt;
  stst_pkg::node_t node_r, node_nxt;
  stst_pkg::sum_t  cur_r, cur_nxt;
  stst_pkg::pos_t  lo_r, lo_nxt;
  stst_pkg::pos_t  hi_r, hi_nxt;
  stst_pkg::sum_t  acc_r, acc_nxt;
  logic            rd_pend_r, rd_pend_nxt;
  logic            v0_r, v0_nxt;
  logic            v1_r, v1_nxt;
  logic            out_valid_r, out_valid_nxt;
  stst_pkg::sum_t  out_sum_r, out_sum_nxt;

  stst_pkg::sum_t  leaf_val;
  stst_pkg::node_t leaf_node;
  stst_pkg::pos_t  first_w;
  stst_pkg::pos_t  end_w;
  stst_pkg::pos_t  end_c;
  stst_pkg::pos_t  hi_m1;
  stst_pkg::node_t parent;
  stst_pkg::sum_t  upd_sum;
  stst_pkg::sum_t  add0;
  stst_pkg::sum_t  add1;

  assign leaf_val  = {{(stst_pkg::SUM_W - stst_pkg::VALUE_W){in_value[stst_pkg::VALUE_W-1]}},
                      in_value};
  assign leaf_node = stst_pkg::node_t'(stst_pkg::NUM_ELEMENTS) +
                     stst_pkg::node_t'(in_index);
  assign first_w   = stst_pkg::pos_t'(in_index);
  assign end_w     = stst_pkg::pos_t'(in_range_end);
  assign end_c     = (end_w > stst_pkg::pos_t'(stst_pkg::NUM_ELEMENTS)) ?
                     stst_pkg::pos_t'(stst_pkg::NUM_ELEMENTS) : end_w;
  assign hi_m1     = hi_r - stst_pkg::pos_t'(1);
  assign parent    = node_r >> 1;
  assign upd_sum   = cur_r + rdata0;
  assign add0      = v0_r ? rdata0 : '0;
  assign add1      = v1_r ? rdata1 : '0;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    node_nxt       = node_r;
    cur_nxt        = cur_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    acc_nxt        = acc_r;
    rd_pend_nxt    = rd_pend_r;
    v0_nxt         = v0_r;
    v1_nxt         = v1_r;
    out_valid_nxt  = 1'b0;
    out_sum_nxt    = out_sum_r;
    mem_req        = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        clr_nxt       = clr_r + stst_pkg::node_t'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_cmd == stst_pkg::CMD_WRITE) begin
            if (first_w < stst_pkg::pos_t'(stst_pkg::NUM_ELEMENTS)) begin
              mem_req.we     = 1'b1;
              mem_req.waddr  = leaf_node;
              mem_req.wdata  = leaf_val;
              mem_req.raddr0 = leaf_node ^ stst_pkg::node_t'(1);
              cur_nxt        = leaf_val;
              node_nxt       = leaf_node;
              state_nxt      = ST_UPD;
            end
          end else if (first_w >= end_c) begin
            out_valid_nxt = 1'b1;
            out_sum_nxt   = '0;
          end else begin
            lo_nxt      = stst_pkg::pos_t'(stst_pkg::NUM_ELEMENTS) + first_w;
            hi_nxt      = stst_pkg::pos_t'(stst_pkg::NUM_ELEMENTS) + end_c;
            acc_nxt     = '0;
            rd_pend_nxt = 1'b0;
            state_nxt   = ST_QRY;
          end
        end
      end
      ST_UPD: begin
        mem_req.we     = 1'b1;
        mem_req.waddr  = parent;
        mem_req.wdata  = upd_sum;
        mem_req.raddr0 = parent ^ stst_pkg::node_t'(1);
        cur_nxt        = upd_sum;
        node_nxt       = parent;
        if (parent == stst_pkg::node_t'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRY: begin
        if (rd_pend_r) begin
          acc_nxt = acc_r + add0 + add1;
        end
        if (lo_r < hi_r) begin
          mem_req.raddr0 = lo_r[stst_pkg::NODE_W-1:0];
          mem_req.raddr1 = hi_m1[stst_pkg::NODE_W-1:0];
          v0_nxt         = lo_r[0];
          v1_nxt         = hi_r[0];
          lo_nxt         = (lo_r + stst_pkg::pos_t'(lo_r[0])) >> 1;
          hi_nxt         = (hi_r - stst_pkg::pos_t'(hi_r[0])) >> 1;
          rd_pend_nxt    = 1'b1;
        end else begin
          rd_pend_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_nxt;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    cur_r     <= cur_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    acc_r     <= acc_nxt;
    v0_r      <= v0_nxt;
    v1_r      <= v1_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  `STST_ASSERT_NR(a_rst_no_result, clk, !rst_n |=> !out_valid_r, "result strobe after reset")
  `STST_ASSERT(a_qry_first_issue, clk, rst_n, (state_r == ST_QRY && !rd_pend_r) |-> (lo_r < hi_r), "query entered with empty range")
  `STST_ASSERT(a_no_node0_write, clk, rst_n, (mem_req.we && state_r != ST_CLEAR) |-> (mem_req.waddr != '0), "write to unused node 0")
  `STST_ASSERT(a_result_source, clk, rst_n, out_valid_r |-> ($past(state_r == ST_QRY) || $past(state_r == ST_IDLE && start && in_cmd == stst_pkg::CMD_QUERY)), "result without a query")
  `STST_ASSERT(a_clear_silent, clk, rst_n, (state_r == ST_CLEAR) |-> (busy && !out_valid_r), "activity during clearing pass")

endmodule

[hw/rtl/segment_tree_range_sum_top.sv]
// ----------------------------------------------------------------------------
// segment_tree_range_sum_top
// Range-sum block over 1024 signed 32-bit elements kept in a segment tree.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a command transfers on a rising edge with start high and
//   busy low. in_cmd selects a write (in_index, in_value) or a query of the
//   half-open range [in_index, in_range_end); in_range_end above 1024 is
//   clamped, an empty or reversed range gives 0.
//   Result channel: each query gives one out_range_sum, marked by a single
//   cycle out_valid strobe; writes give none. The receiver cannot stall, the
//   result register is independent of the input side.
//   Write: busy for 10 cycles after the transfer, one tree level per cycle
//   (read sibling from the node memory, add, write parent).
//   Query: empty range gives the result the cycle after the transfer with
//   busy staying low; otherwise the walk climbs at most 11 tree levels,
//   reading both range ends per cycle on two memory read ports.
//   Reset: a clearing pass zeroes all 2048 tree nodes, one per cycle, with
//   busy high for 2048 cycles after reset is released.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_cmd,
  input  logic [stst_pkg::IDX_W-1:0]           in_index,
  input  logic [stst_pkg::END_W-1:0]           in_range_end,
  input  logic signed [stst_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  output logic signed [stst_pkg::SUM_W-1:0]    out_range_sum
);

  stst_pkg::mem_req_t mem_req;
  stst_pkg::sum_t     rdata0;
  stst_pkg::sum_t     rdata1;

  stst_walk u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_index      (in_index),
    .in_range_end  (in_range_end),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_range_sum (out_range_sum),
    .mem_req       (mem_req),
    .rdata0        (rdata0),
    .rdata1        (rdata1)
  );

  stst_tree_mem u_mem (
    .clk    (clk),
    .req    (mem_req),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

endmodule

[bench/segment_tree_range_sum_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum_top_tb
// Self-checking bench for the segment tree range-sum block.
// ----------------------------------------------------------------------------
// Sends element writes and range queries with random idle gaps. It keeps its
// own node-sum tree to predict the sum of each query, and checks every
// out_valid transfer against the oldest pending sum.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_top_tb;

  logic                                 clk          = 1'b0;
  logic                                 rst_n        = 1'b0;
  logic                                 start        = 1'b0;
  logic                                 busy;
  logic                                 in_cmd       = stst_pkg::CMD_WRITE;
  logic [stst_pkg::IDX_W-1:0]           in_index     = '0;
  logic [stst_pkg::END_W-1:0]           in_range_end = '0;
  logic signed [stst_pkg::VALUE_W-1:0]  in_value     = '0;
  logic                                 out_valid;
  logic signed [stst_pkg::SUM_W-1:0]    out_range_sum;

  bit [63:0]                  tree_sums [stst_pkg::TREE_NODES];
  logic [stst_pkg::SUM_W-1:0] pending_sums [$];
  logic [stst_pkg::SUM_W-1:0] due_sum;
  int unsigned                mismatches = 0;
  int unsigned                calm_left  = 0;

  localparam logic signed [stst_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [stst_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  segment_tree_range_sum_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_index      (in_index),
    .in_range_end  (in_range_end),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_range_sum (out_range_sum)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic store_element(input int unsigned pos,
                               input logic signed [stst_pkg::VALUE_W-1:0] val);
    int unsigned node;
    node = pos + stst_pkg::NUM_ELEMENTS;
    tree_sums[node] = {{32{val[stst_pkg::VALUE_W-1]}}, val};
    for (node = node >> 1; node > 0; node = node >> 1)
      tree_sums[node] = tree_sums[2*node] + tree_sums[2*node+1];
  endtask

  function automatic logic [stst_pkg::SUM_W-1:0] sum_range(input int unsigned first,
                                                           input int unsigned stop);
    bit [63:0]   acc;
    int unsigned lo;
    int unsigned hi;
    acc = '0;
    if (stop > stst_pkg::NUM_ELEMENTS) stop = stst_pkg::NUM_ELEMENTS;
    if (first >= stop) return '0;
    lo = first + stst_pkg::NUM_ELEMENTS;
    hi = stop + stst_pkg::NUM_ELEMENTS;
    while (lo < hi) begin
      if ((lo & 1) != 0) begin
        acc += tree_sums[lo];
        lo++;
      end
      if ((hi & 1) != 0) begin
        hi--;
        acc += tree_sums[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return acc[stst_pkg::SUM_W-1:0];
  endfunction

  // mostly back-to-back, some short gaps, a few long ones, and calm stretches
  function automatic int unsigned idle_len();
    int unsigned roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      calm_left = $urandom_range(60, 20);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_item(input logic cmd, input int unsigned idx, input int unsigned stop,
                           input logic signed [stst_pkg::VALUE_W-1:0] val);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_index     <= idx[stst_pkg::IDX_W-1:0];
    in_range_end <= stop[stst_pkg::END_W-1:0];
    in_value     <= val;
    do @(posedge clk); while (busy);
    if (cmd == stst_pkg::CMD_WRITE) begin
      if (idx < stst_pkg::NUM_ELEMENTS) store_element(idx, val);
    end else begin
      pending_sums.push_back(sum_range(idx, stop));
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_sums.size() == 0) begin
        $error("range_sum: expected none, actual %0d", out_range_sum);
        mismatches++;
      end else begin
        due_sum = pending_sums.pop_front();
        if (out_range_sum !== due_sum) begin
          $error("range_sum: expected %0d, actual %0d", $signed(due_sum), out_range_sum);
          mismatches++;
        end
      end
    end
  end

  task automatic test_cleared_tree();
    send_item(stst_pkg::CMD_QUERY, 0, stst_pkg::NUM_ELEMENTS, '0);
    send_item(stst_pkg::CMD_QUERY, 0, 2047, VAL_MAX);
    send_item(stst_pkg::CMD_QUERY, 512, 513, '0);
  endtask

  task automatic test_directed_edges();
    send_item(stst_pkg::CMD_WRITE, 0, 2047, VAL_MAX);
    send_item(stst_pkg::CMD_WRITE, stst_pkg::NUM_ELEMENTS - 1, 0, VAL_MIN);
    send_item(stst_pkg::CMD_WRITE, 1, 0, -32'sd1);
    send_item(stst_pkg::CMD_WRITE, 512, 0, 32'sh5555_5555);
    send_item(stst_pkg::CMD_WRITE, 1022, 0, 32'shAAAA_AAAA);
    send_item(stst_pkg::CMD_QUERY, 0, 1, '0);
    send_item(stst_pkg::CMD_QUERY, stst_pkg::NUM_ELEMENTS - 1, stst_pkg::NUM_ELEMENTS, '0);
    send_item(stst_pkg::CMD_QUERY, 0, stst_pkg::NUM_ELEMENTS, '0);
    send_item(stst_pkg::CMD_QUERY, 0, 2047, '0);
    send_item(stst_pkg::CMD_QUERY, stst_pkg::NUM_ELEMENTS - 1, 2047, '0);
    send_item(stst_pkg::CMD_QUERY, 1, 513, VAL_MIN);
    // reversed and empty ranges
    send_item(stst_pkg::CMD_QUERY, 5, 3, '0);
    send_item(stst_pkg::CMD_QUERY, 7, 7, '0);
    send_item(stst_pkg::CMD_QUERY, stst_pkg::NUM_ELEMENTS - 1, 0, '0);
    send_item(stst_pkg::CMD_QUERY, 0, 0, '0);
    send_item(stst_pkg::CMD_WRITE, 0, 0, '0);
    send_item(stst_pkg::CMD_QUERY, 0, 2, '0);
    send_item(stst_pkg::CMD_QUERY, 2, stst_pkg::NUM_ELEMENTS, '0);
  endtask

  // the upper half at the most negative value drives a deep negative sum
  task automatic test_fill_extreme();
    int unsigned pos;
    for (pos = stst_pkg::NUM_ELEMENTS / 2; pos < stst_pkg::NUM_ELEMENTS; pos++) begin
      send_item(stst_pkg::CMD_WRITE, pos, $urandom_range(2047), VAL_MIN);
      if (pos % 64 == 63) begin
        send_item(stst_pkg::CMD_QUERY, stst_pkg::NUM_ELEMENTS / 2, pos + 1, '0);
        send_item(stst_pkg::CMD_QUERY, $urandom_range(stst_pkg::NUM_ELEMENTS - 1),
                  $urandom_range(2047), $urandom);
      end
    end
    send_item(stst_pkg::CMD_QUERY, stst_pkg::NUM_ELEMENTS / 2, stst_pkg::NUM_ELEMENTS, '0);
    send_item(stst_pkg::CMD_QUERY, 0, 2047, '0);
  endtask

  task automatic test_random_mixed(input int unsigned count);
    int unsigned n;
    int unsigned roll;
    int unsigned idx;
    int unsigned stop;
    logic signed [stst_pkg::VALUE_W-1:0] val;
    logic cmd;
    for (n = 0; n < count; n++) begin
      cmd  = ($urandom_range(1) == 0) ? stst_pkg::CMD_WRITE : stst_pkg::CMD_QUERY;
      roll = $urandom_range(99);
      if (roll < 10)      idx = 0;
      else if (roll < 20) idx = stst_pkg::NUM_ELEMENTS - 1;
      else                idx = $urandom_range(stst_pkg::NUM_ELEMENTS - 1);
      roll = $urandom_range(99);
      if (roll < 40)      stop = $urandom_range(stst_pkg::NUM_ELEMENTS);
      else if (roll < 60) stop = idx + $urandom_range(8);
      else if (roll < 80) stop = $urandom_range(2047, stst_pkg::NUM_ELEMENTS);
      else                stop = $urandom_range(2047);
      roll = $urandom_range(99);
      if (roll < 5)       val = VAL_MAX;
      else if (roll < 10) val = VAL_MIN;
      else if (roll < 15) val = '0;
      else if (roll < 20) val = -32'sd1;
      else                val = $urandom;
      send_item(cmd, idx, stop, val);
    end
  endtask

  initial begin
    int unsigned drain;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_cleared_tree();
    test_directed_edges();
    test_fill_extreme();
    test_random_mixed(350);
    start <= 1'b0;
    drain = 0;
    while (pending_sums.size() != 0 && drain < 1000) begin
      @(negedge clk);
      drain++;
    end
    repeat (30) @(negedge clk);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
